@@ hdl/ytb_pkg.sv @@
// types and constants shared by the yuyv to bgr converter
package ytb_pkg;

	localparam int COEF_W   = 16;
	localparam int CHROMA_W = 8;
	localparam int PROD_W   = COEF_W + CHROMA_W;
	localparam int SUM_W    = PROD_W + 1;
	localparam int INDEX_W  = 3;

	localparam logic [INDEX_W-1:0] REG_BLUE_FROM_U  = 3'd0;
	localparam logic [INDEX_W-1:0] REG_GREEN_FROM_U = 3'd1;
	localparam logic [INDEX_W-1:0] REG_GREEN_FROM_V = 3'd2;
	localparam logic [INDEX_W-1:0] REG_RED_FROM_V   = 3'd3;

	localparam logic signed [COEF_W-1:0] RST_BLUE_FROM_U  = 16'sd14499;
	localparam logic signed [COEF_W-1:0] RST_GREEN_FROM_U = -16'sd2809;
	localparam logic signed [COEF_W-1:0] RST_GREEN_FROM_V = -16'sd5849;
	localparam logic signed [COEF_W-1:0] RST_RED_FROM_V   = 16'sd11493;

	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] chroma_blue;
		logic [7:0] luma_second;
		logic [7:0] chroma_red;
	} yuyv_t;

	typedef struct packed {
		logic [7:0] blue_first;
		logic [7:0] green_first;
		logic [7:0] red_first;
		logic [7:0] blue_second;
		logic [7:0] green_second;
		logic [7:0] red_second;
	} bgr_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] blue_from_u;
		logic signed [COEF_W-1:0] green_from_u;
		logic signed [COEF_W-1:0] green_from_v;
		logic signed [COEF_W-1:0] red_from_v;
	} coef_set_t;

	typedef struct packed {
		logic [7:0]               luma_first;
		logic [7:0]               luma_second;
		logic signed [PROD_W-1:0] blue_u;
		logic signed [PROD_W-1:0] green_u;
		logic signed [PROD_W-1:0] green_v;
		logic signed [PROD_W-1:0] red_v;
	} prod_set_t;

endpackage

@@ hdl/ytb_coef_regs.sv @@
// coefficient register file written through the configuration port
module ytb_coef_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [ytb_pkg::INDEX_W-1:0] cfg_index,
	input  logic [ytb_pkg::COEF_W-1:0]  cfg_data,
	output ytb_pkg::coef_set_t          coefs
);
	import ytb_pkg::*;

	coef_set_t coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.blue_from_u  <= RST_BLUE_FROM_U;
			coefs_q.green_from_u <= RST_GREEN_FROM_U;
			coefs_q.green_from_v <= RST_GREEN_FROM_V;
			coefs_q.red_from_v   <= RST_RED_FROM_V;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_BLUE_FROM_U:  coefs_q.blue_from_u  <= cfg_data;
				REG_GREEN_FROM_U: coefs_q.green_from_u <= cfg_data;
				REG_GREEN_FROM_V: coefs_q.green_from_v <= cfg_data;
				REG_RED_FROM_V:   coefs_q.red_from_v   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coefs = coefs_q;

endmodule

@@ hdl/ytb_product_pipe.sv @@
// input register stage and chroma coefficient multiplier stage
module ytb_product_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ytb_pkg::yuyv_t     in_item,
	input  ytb_pkg::coef_set_t coefs,
	output logic               out_valid,
	input  logic               out_ready,
	output ytb_pkg::prod_set_t out_prod
);
	import ytb_pkg::*;

	logic                       valid_s1;
	logic [7:0]                 luma_first_s1;
	logic [7:0]                 luma_second_s1;
	logic signed [CHROMA_W-1:0] u_s1;
	logic signed [CHROMA_W-1:0] v_s1;
	logic                       ready_s1;

	logic                       valid_s2;
	prod_set_t                  prod_s2;
	logic                       ready_s2;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// centring by 128 is an msb flip
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			luma_first_s1  <= in_item.luma_first;
			luma_second_s1 <= in_item.luma_second;
			u_s1           <= {~in_item.chroma_blue[7], in_item.chroma_blue[6:0]};
			v_s1           <= {~in_item.chroma_red[7], in_item.chroma_red[6:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			prod_s2.luma_first  <= luma_first_s1;
			prod_s2.luma_second <= luma_second_s1;
			prod_s2.blue_u      <= PROD_W'(coefs.blue_from_u) * PROD_W'(u_s1);
			prod_s2.green_u     <= PROD_W'(coefs.green_from_u) * PROD_W'(u_s1);
			prod_s2.green_v     <= PROD_W'(coefs.green_from_v) * PROD_W'(v_s1);
			prod_s2.red_v       <= PROD_W'(coefs.red_from_v) * PROD_W'(v_s1);
		end
	end

	assign out_valid = valid_s2;
	assign out_prod  = prod_s2;

endmodule

@@ hdl/ytb_round_clamp.sv @@
// rounding stage and luma add with clamp output stage
module ytb_round_clamp #(
	parameter int FRACTION_BITS = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ytb_pkg::prod_set_t in_prod,
	output logic               out_valid,
	input  logic               out_ready,
	output ytb_pkg::bgr_t      out_item
);
	import ytb_pkg::*;

	localparam int CORR_W = SUM_W - FRACTION_BITS;
	localparam int PIX_W  = CORR_W + 1;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRACTION_BITS - 1);

	function automatic logic [7:0] clamp_pix(input logic signed [PIX_W-1:0] val);
		logic [7:0] res;
		if (val < 0) begin
			res = 8'd0;
		end else if (val > PIX_W'(255)) begin
			res = 8'd255;
		end else begin
			res = val[7:0];
		end
		return res;
	endfunction

	logic signed [SUM_W-1:0]  sum_b;
	logic signed [SUM_W-1:0]  sum_g;
	logic signed [SUM_W-1:0]  sum_r;

	logic                     valid_s3;
	logic [7:0]               luma_first_s3;
	logic [7:0]               luma_second_s3;
	logic signed [CORR_W-1:0] corr_b_s3;
	logic signed [CORR_W-1:0] corr_g_s3;
	logic signed [CORR_W-1:0] corr_r_s3;
	logic                     ready_s3;

	logic                     valid_s4;
	bgr_t                     item_s4;
	logic                     ready_s4;

	logic signed [PIX_W-1:0]  y0_ext;
	logic signed [PIX_W-1:0]  y1_ext;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;

	assign sum_b = SUM_W'(in_prod.blue_u) + HALF;
	assign sum_g = SUM_W'(in_prod.green_u) + SUM_W'(in_prod.green_v) + HALF;
	assign sum_r = SUM_W'(in_prod.red_v) + HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= in_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// dropping the low bits floors toward minus infinity
	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			luma_first_s3  <= in_prod.luma_first;
			luma_second_s3 <= in_prod.luma_second;
			corr_b_s3      <= sum_b[SUM_W-1:FRACTION_BITS];
			corr_g_s3      <= sum_g[SUM_W-1:FRACTION_BITS];
			corr_r_s3      <= sum_r[SUM_W-1:FRACTION_BITS];
		end
	end

	assign y0_ext = {{(PIX_W-8){1'b0}}, luma_first_s3};
	assign y1_ext = {{(PIX_W-8){1'b0}}, luma_second_s3};

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			item_s4.blue_first   <= clamp_pix(y0_ext + PIX_W'(corr_b_s3));
			item_s4.green_first  <= clamp_pix(y0_ext + PIX_W'(corr_g_s3));
			item_s4.red_first    <= clamp_pix(y0_ext + PIX_W'(corr_r_s3));
			item_s4.blue_second  <= clamp_pix(y1_ext + PIX_W'(corr_b_s3));
			item_s4.green_second <= clamp_pix(y1_ext + PIX_W'(corr_g_s3));
			item_s4.red_second   <= clamp_pix(y1_ext + PIX_W'(corr_r_s3));
		end
	end

	assign out_valid = valid_s4;
	assign out_item  = item_s4;

endmodule

@@ hdl/yuyv_to_bgr_pixel_pair_top.sv @@
// top level of the yuyv macropixel to bgr pixel pair converter
//
// the yuyv channel takes one macropixel (two luma bytes, shared u and v) per
// transaction; the bgr channel returns both pixels as blue, green, red bytes
// in one transaction. both channels use valid/ready.
// four register stages: input, coefficient multiply, round, luma add and
// clamp. one transaction is accepted every cycle while bgr_ready is high.
// each stage holds its data when the stage after it is full and stalled, so
// a stalled receiver backs the pipeline up one stage at a time; bubbles are
// squeezed out and nothing is lost or repeated.
// the four q13 coefficients sit in registers written through cfg_wen,
// cfg_index and cfg_data; writes to an unused index are dropped. write them
// only while the pipeline is empty.
// reset empties the pipeline and loads the bt.601 full range coefficients.
module yuyv_to_bgr_pixel_pair_top #(
	parameter int FRACTION_BITS = 13
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        yuyv_valid,
	output logic                        yuyv_ready,
	input  ytb_pkg::yuyv_t              yuyv,
	output logic                        bgr_valid,
	input  logic                        bgr_ready,
	output ytb_pkg::bgr_t               bgr,
	input  logic                        cfg_wen,
	input  logic [ytb_pkg::INDEX_W-1:0] cfg_index,
	input  logic [ytb_pkg::COEF_W-1:0]  cfg_data
);
	import ytb_pkg::*;

	coef_set_t coefs;
	prod_set_t prod;
	logic      prod_valid;
	logic      prod_ready;

	ytb_coef_regs u_coef_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coefs     (coefs)
	);

	ytb_product_pipe u_product_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (yuyv_valid),
		.in_ready  (yuyv_ready),
		.in_item   (yuyv),
		.coefs     (coefs),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_prod  (prod)
	);

	ytb_round_clamp #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_round_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prod_valid),
		.in_ready  (prod_ready),
		.in_prod   (prod),
		.out_valid (bgr_valid),
		.out_ready (bgr_ready),
		.out_item  (bgr)
	);

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the yuyv to bgr pixel pair converter
module tb_top;
	import ytb_pkg::*;

	localparam int FRAC_BITS   = 13;
	localparam longint CHROMA_MID = 128;
	localparam int PHASES      = 8;
	localparam int RAND_ITEMS  = 141;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_WAIT  = 12;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 yuyv_valid = 1'b0;
	logic                 yuyv_ready;
	yuyv_t                yuyv = '0;
	logic                 bgr_valid;
	logic                 bgr_ready = 1'b0;
	bgr_t                 bgr;
	logic                 cfg_wen = 1'b0;
	logic [INDEX_W-1:0]   cfg_index = '0;
	logic [COEF_W-1:0]    cfg_data = '0;

	coef_set_t coefs;
	yuyv_t     pending_px[$];
	bgr_t      expected_bgr[$];
	bgr_t      want;
	int        mismatch_count = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	bit        hold_request = 1'b0;
	int        hold_left = 0;
	int        quiet_cycles = 0;

	yuyv_to_bgr_pixel_pair_top #(
		.FRACTION_BITS(FRAC_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.yuyv_valid (yuyv_valid),
		.yuyv_ready (yuyv_ready),
		.yuyv       (yuyv),
		.bgr_valid  (bgr_valid),
		.bgr_ready  (bgr_ready),
		.bgr        (bgr),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] clamp_to_byte(longint x);
		if (x < 0)
			return 8'd0;
		if (x > 255)
			return 8'd255;
		return x[7:0];
	endfunction

	function automatic longint rounded_corr(longint weighted);
		longint half;
		half = longint'(1) <<< (FRAC_BITS - 1);
		return (weighted + half) >>> FRAC_BITS;
	endfunction

	function automatic bgr_t convert_pair(yuyv_t px);
		longint u, v, y0, y1, cb, cg, cr;
		bgr_t r;
		y0 = longint'(px.luma_first);
		y1 = longint'(px.luma_second);
		u  = longint'(px.chroma_blue) - CHROMA_MID;
		v  = longint'(px.chroma_red) - CHROMA_MID;
		cb = rounded_corr(longint'(coefs.blue_from_u) * u);
		cg = rounded_corr(longint'(coefs.green_from_u) * u + longint'(coefs.green_from_v) * v);
		cr = rounded_corr(longint'(coefs.red_from_v) * v);
		r.blue_first   = clamp_to_byte(y0 + cb);
		r.green_first  = clamp_to_byte(y0 + cg);
		r.red_first    = clamp_to_byte(y0 + cr);
		r.blue_second  = clamp_to_byte(y1 + cb);
		r.green_second = clamp_to_byte(y1 + cg);
		r.red_second   = clamp_to_byte(y1 + cr);
		return r;
	endfunction

	function automatic logic [7:0] pick_byte();
		logic [7:0] corner_bytes[4];
		corner_bytes = '{8'd0, 8'd127, 8'd128, 8'd255};
		if ($urandom_range(7) == 0)
			return corner_bytes[$urandom_range(3)];
		return 8'($urandom_range(255));
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch: %0s", msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%0s got %0d expected %0d", name, got, exp_val));
	endtask

	task automatic write_reg(logic [INDEX_W-1:0] idx, logic [COEF_W-1:0] data);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
	endtask

	// unused indexes get garbage that must not land anywhere
	task automatic load_coefs(coef_set_t c);
		write_reg(REG_BLUE_FROM_U, c.blue_from_u);
		write_reg(REG_GREEN_FROM_U, c.green_from_u);
		write_reg(REG_GREEN_FROM_V, c.green_from_v);
		write_reg(REG_RED_FROM_V, c.red_from_v);
		for (int i = int'(REG_RED_FROM_V) + 1; i < (1 << INDEX_W); i++)
			write_reg(INDEX_W'(i), COEF_W'($urandom));
		@(posedge clk);
		cfg_wen <= 1'b0;
		coefs = c;
	endtask

	task automatic drain();
		while (pending_px.size() != 0 || yuyv_valid || expected_bgr.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yuyv_valid <= 1'b0;
		end else begin
			if (yuyv_valid && yuyv_ready)
				expected_bgr.push_back(convert_pair(yuyv));
			if (!yuyv_valid || yuyv_ready) begin
				if (pending_px.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					yuyv       <= pending_px.pop_front();
					yuyv_valid <= 1'b1;
				end else begin
					yuyv_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bgr_ready <= 1'b0;
		end else begin
			if (bgr_valid && bgr_ready) begin
				if (expected_bgr.size() == 0) begin
					report_mismatch("bgr transaction with nothing expected");
				end else begin
					want = expected_bgr.pop_front();
					check_field("blue_first", bgr.blue_first, want.blue_first);
					check_field("green_first", bgr.green_first, want.green_first);
					check_field("red_first", bgr.red_first, want.red_first);
					check_field("blue_second", bgr.blue_second, want.blue_second);
					check_field("green_second", bgr.green_second, want.green_second);
					check_field("red_second", bgr.red_second, want.red_second);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				bgr_ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
				bgr_ready <= 1'b0;
			end else begin
				bgr_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((yuyv_valid && yuyv_ready) || (bgr_valid && bgr_ready) || cfg_wen)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] chroma_pts[5];
		logic [7:0] luma_pts[3];
		coef_set_t  c;
		coefs.blue_from_u  = RST_BLUE_FROM_U;
		coefs.green_from_u = RST_GREEN_FROM_U;
		coefs.green_from_v = RST_GREEN_FROM_V;
		coefs.red_from_v   = RST_RED_FROM_V;
		chroma_pts = '{8'd0, 8'd127, 8'd128, 8'd129, 8'd255};
		luma_pts   = '{8'd0, 8'd128, 8'd255};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			c = coefs;
			case (ph)
				1: c = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
				2: c = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
				3: c = '0;
				4: c = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff};
				5, 6: c = COEF_W * 4'($urandom) == 0 ? '0 : {$urandom, $urandom};
				7: c = '{RST_BLUE_FROM_U, RST_GREEN_FROM_U, RST_GREEN_FROM_V, RST_RED_FROM_V};
				default: ;
			endcase
			if (ph != 0)
				load_coefs(c);

			if (ph == 0) begin
				// chroma extremes and the rounding points around neutral for u, extremes and neutral for v
				for (int i = 0; i < 5; i++)
					for (int j = 0; j < 5; j += 2)
						pending_px.push_back('{luma_first: luma_pts[(i + j) % 3],
							chroma_blue: chroma_pts[i],
							luma_second: luma_pts[(i + j + 1) % 3],
							chroma_red: chroma_pts[j]});
				pending_px.push_back('0);
				pending_px.push_back('1);
				pending_px.push_back('{8'd255, 8'd0, 8'd0, 8'd255});
				pending_px.push_back('{8'd0, 8'd255, 8'd255, 8'd0});
			end
			if (ph == 4)
				hold_request = 1'b1;
			for (int k = 0; k < RAND_ITEMS; k++)
				pending_px.push_back('{pick_byte(), pick_byte(), pick_byte(), pick_byte()});
			drain();
		end

		if (mismatch_count == 0 && expected_bgr.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
